// ----- design/lse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and codes for the leaky integrate-and-fire layer engine.
// ----------------------------------------------------------------------------
package lse_pkg;

   typedef logic [1:0]         mode_type;
   typedef logic [9:0]         pre_index_type;
   typedef logic [7:0]         post_index_type;
   typedef logic signed [15:0] weight_type;
   typedef logic signed [31:0] membrane_type;
   typedef logic [30:0]        threshold_type;
   typedef logic [8:0]         decay_type;
   typedef logic [1:0]         csr_index_type;
   typedef logic [31:0]        csr_data_type;

   localparam mode_type MODE_LOAD  = 2'd0;
   localparam mode_type MODE_CLEAR = 2'd1;
   localparam mode_type MODE_SPIKE = 2'd2;
   localparam mode_type MODE_EVAL  = 2'd3;

   localparam csr_index_type CSR_FIRE_THRESHOLD = 2'd0;
   localparam csr_index_type CSR_DECAY_FACTOR   = 2'd1;

   localparam threshold_type THRESHOLD_RESET = 31'd256;
   localparam decay_type     DECAY_RESET     = 9'd192;

   localparam membrane_type MEMBRANE_MAX = 32'sh7FFF_FFFF;
   localparam membrane_type MEMBRANE_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

// ----- design/lse_channels.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lse channels
// Valid/ready channels: request, response and register write.
// ----------------------------------------------------------------------------
interface lse_req_if;
   logic                   valid;
   logic                   ready;
   lse_pkg::mode_type      mode;
   lse_pkg::pre_index_type pre_index;
   lse_pkg::post_index_type post_index;
   lse_pkg::weight_type    weight_value;

   modport source (output valid, mode, pre_index, post_index, weight_value, input ready);
   modport sink   (input valid, mode, pre_index, post_index, weight_value, output ready);
endinterface

interface lse_rsp_if;
   logic                    valid;
   logic                    ready;
   lse_pkg::post_index_type neuron_number;
   logic                    fired;
   lse_pkg::membrane_type   membrane_before;

   modport source (output valid, neuron_number, fired, membrane_before, input ready);
   modport sink   (input valid, neuron_number, fired, membrane_before, output ready);
endinterface

interface lse_csr_if;
   logic                   valid;
   logic                   ready;
   lse_pkg::csr_index_type index;
   lse_pkg::csr_data_type  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/lse_weight_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lse_weight_mem
// Synaptic weight store, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lse_weight_mem #(
   parameter int DEPTH  = 262144,
   parameter int ADDR_W = 18
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire lse_pkg::weight_type wr_data,
   input  wire logic                rd_en,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output lse_pkg::weight_type      rd_data
);

   lse_pkg::weight_type mem [DEPTH];
   lse_pkg::weight_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/lse_leak_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lse_leak_unit
// Membrane leak: registered v*decay, then arithmetic shift by 8 and saturate.
// ----------------------------------------------------------------------------
module lse_leak_unit (
   input  wire logic                  clock,
   input  wire logic                  load,
   input  wire lse_pkg::membrane_type value,
   input  wire lse_pkg::decay_type    decay,
   output lse_pkg::membrane_type      result
);

   logic signed [41:0] prod_in;
   logic signed [41:0] prod_ff;
   logic signed [33:0] shifted;

   assign prod_in = 42'(value) * 42'($signed({1'b0, decay}));

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // arithmetic shift is floor division by 256
   assign shifted = $signed(prod_ff[41:8]);

   always_comb begin
      priority if (shifted > 34'(lse_pkg::MEMBRANE_MAX)) begin
         result = lse_pkg::MEMBRANE_MAX;
      end else if (shifted < 34'(lse_pkg::MEMBRANE_MIN)) begin
         result = lse_pkg::MEMBRANE_MIN;
      end else begin
         result = shifted[31:0];
      end
   end

endmodule
`default_nettype wire

// ----- design/lif_spiking_layer_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lif_spiking_layer_engine
// One leaky integrate-and-fire layer: weight load, membrane clear, spike
// accumulation over all neurons and single-neuron evaluation.
// ----------------------------------------------------------------------------
// Load: weight written from the LOAD state. Clear: one membrane write per
// cycle. Spike: one neuron read-modify-write per cycle through the membrane
// memory. Evaluate: EVAL_RD, EVAL_MUL, EVAL_WB, leak multiply registered;
// EVAL_WB waits while the response is unread. One request at a time; the
// response register frees the request side. After reset a clearing pass of
// every membrane runs before the first request; register writes any time.
module lif_spiking_layer_engine #(
   parameter int NEURONS = 256,
   parameter int INPUTS  = 1024
) (
   input wire logic clock,
   input wire logic reset,
   lse_req_if.sink   req_if,
   lse_rsp_if.source rsp_if,
   lse_csr_if.sink   csr_if
);

   localparam int NADDR_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int NCNT_W  = $clog2(NEURONS + 1);
   localparam int WDEPTH  = INPUTS * NEURONS;
   localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_LOAD     = 3'd1;
   localparam logic [2:0] ST_CLEAR    = 3'd2;
   localparam logic [2:0] ST_SPIKE    = 3'd3;
   localparam logic [2:0] ST_EVAL_RD  = 3'd4;
   localparam logic [2:0] ST_EVAL_MUL = 3'd5;
   localparam logic [2:0] ST_EVAL_WB  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [NCNT_W-1:0]   cnt_ff, cnt_in;
   logic                stage_vld_ff, stage_vld_in;
   logic [NADDR_W-1:0]  stage_idx_ff, stage_idx_in;
   logic [WADDR_W-1:0]  waddr_ff, waddr_in;
   lse_pkg::post_index_type post_ff;
   lse_pkg::weight_type     wv_ff;
   lse_pkg::membrane_type   v_ff;
   logic                    fire_ff, fire_in;
   lse_pkg::threshold_type  thr_ff;
   lse_pkg::decay_type      decay_ff;
   logic                    rsp_vld_ff;
   lse_pkg::post_index_type rsp_num_ff;
   logic                    rsp_fired_ff;
   lse_pkg::membrane_type   rsp_before_ff;

   lse_pkg::membrane_type membrane_mem [NEURONS];
   lse_pkg::membrane_type mrd_ff;
   logic                  mem_we, mem_rd_en;
   logic [NADDR_W-1:0]    mem_waddr, mem_raddr;
   lse_pkg::membrane_type mem_wdata;

   logic                  w_wr_en, w_rd_en;
   logic [WADDR_W-1:0]    w_wr_addr;
   lse_pkg::weight_type   wrd;

   logic                  leak_load, rsp_load;
   lse_pkg::membrane_type leak_result;
   logic                  req_fire, pre_ok, post_ok;
   logic [WADDR_W-1:0]    base;
   logic signed [32:0]    spike_sum;
   lse_pkg::membrane_type spike_sat;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign pre_ok       = 32'(req_if.pre_index) < 32'(INPUTS);
   assign post_ok      = 32'(req_if.post_index) < 32'(NEURONS);
   assign base         = WADDR_W'(32'(req_if.pre_index) * 32'(NEURONS));
   assign w_wr_addr    = waddr_ff + WADDR_W'(post_ff);

   assign spike_sum = 33'(mrd_ff) + 33'(wrd);
   always_comb begin
      priority if (spike_sum[32] != spike_sum[31]) begin
         spike_sat = spike_sum[32] ? lse_pkg::MEMBRANE_MIN : lse_pkg::MEMBRANE_MAX;
      end else begin
         spike_sat = spike_sum[31:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      stage_vld_in = 1'b0;
      stage_idx_in = stage_idx_ff;
      waddr_in     = waddr_ff;
      fire_in      = fire_ff;
      mem_we       = 1'b0;
      mem_waddr    = stage_idx_ff;
      mem_wdata    = spike_sat;
      mem_rd_en    = 1'b0;
      mem_raddr    = cnt_ff[NADDR_W-1:0];
      w_wr_en      = 1'b0;
      w_rd_en      = 1'b0;
      leak_load    = 1'b0;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               waddr_in = base;
               cnt_in   = '0;
               unique case (req_if.mode)
                  lse_pkg::MODE_LOAD: begin
                     if (pre_ok && post_ok) state_in = ST_LOAD;
                  end
                  lse_pkg::MODE_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  lse_pkg::MODE_SPIKE: begin
                     if (pre_ok) state_in = ST_SPIKE;
                  end
                  lse_pkg::MODE_EVAL: begin
                     if (post_ok) state_in = ST_EVAL_RD;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            w_wr_en  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[NADDR_W-1:0];
            mem_wdata = '0;
            if (cnt_ff == NCNT_W'(NEURONS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SPIKE: begin
            if (stage_vld_ff) begin
               mem_we = 1'b1;
            end
            if (cnt_ff != NCNT_W'(NEURONS)) begin
               mem_rd_en    = 1'b1;
               w_rd_en      = 1'b1;
               stage_vld_in = 1'b1;
               stage_idx_in = cnt_ff[NADDR_W-1:0];
               cnt_in       = cnt_ff + 1'b1;
               waddr_in     = waddr_ff + 1'b1;
            end else if (!stage_vld_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_EVAL_RD: begin
            mem_rd_en = 1'b1;
            mem_raddr = NADDR_W'(post_ff);
            state_in  = ST_EVAL_MUL;
         end
         ST_EVAL_MUL: begin
            leak_load = 1'b1;
            fire_in   = $signed({mrd_ff[31], mrd_ff}) > $signed({2'b00, thr_ff});
            state_in  = ST_EVAL_WB;
         end
         ST_EVAL_WB: begin
            if (!rsp_vld_ff || rsp_if.ready) begin
               rsp_load  = 1'b1;
               mem_we    = 1'b1;
               mem_waddr = NADDR_W'(post_ff);
               mem_wdata = fire_ff ? '0 : leak_result;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         stage_vld_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_idx_ff <= stage_idx_in;
      waddr_ff     <= waddr_in;
      fire_ff      <= fire_in;
      if (req_fire) begin
         post_ff <= req_if.post_index;
         wv_ff   <= req_if.weight_value;
      end
      if (leak_load) begin
         v_ff <= mrd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         membrane_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_rd_en) begin
         mrd_ff <= membrane_mem[mem_raddr];
      end
   end

   // register file
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= lse_pkg::THRESHOLD_RESET;
         decay_ff <= lse_pkg::DECAY_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            lse_pkg::CSR_FIRE_THRESHOLD: begin
               thr_ff <= csr_if.data[30:0];
            end
            lse_pkg::CSR_DECAY_FACTOR: begin
               decay_ff <= csr_if.data[8:0];
            end
            default: begin
            end
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_num_ff    <= post_ff;
         rsp_fired_ff  <= fire_ff;
         rsp_before_ff <= v_ff;
      end
   end

   assign rsp_if.valid           = rsp_vld_ff;
   assign rsp_if.neuron_number   = rsp_num_ff;
   assign rsp_if.fired           = rsp_fired_ff;
   assign rsp_if.membrane_before = rsp_before_ff;

   lse_weight_mem #(
      .DEPTH  (WDEPTH),
      .ADDR_W (WADDR_W)
   ) u_weight_mem (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (wv_ff),
      .rd_en   (w_rd_en),
      .rd_addr (waddr_ff),
      .rd_data (wrd)
   );

   lse_leak_unit u_leak_unit (
      .clock  (clock),
      .load   (leak_load),
      .value  (mrd_ff),
      .decay  (decay_ff),
      .result (leak_result)
   );

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_rd_en) |-> (mem_waddr != mem_raddr))
      else $error("membrane read and write hit the same neuron");

   a_rsp_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> ($past(state_ff) == ST_EVAL_WB))
      else $error("response raised outside evaluation");

   a_clear_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!mem_rd_en && !w_rd_en))
      else $error("read issued during clearing pass");

   a_stage_from_spike: assert property (@(posedge clock) disable iff (reset)
      stage_vld_ff |-> ($past(state_ff) == ST_SPIKE))
      else $error("spike writeback without spike issue");

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LIF layer engine. Loads complete weight rows,
// then runs directed and random phases of loads, clears, spikes and neuron
// evaluations. Both channels idle in random bursts, and register settings
// change between phases. A shadow copy of the layer predicts each evaluation
// response, and every response is compared field by field.
// ----------------------------------------------------------------------------
module tb;

   localparam int NEURONS = 256;
   localparam int INPUTS  = 1024;
   localparam int SETTLE  = NEURONS + 16;
   localparam int LIMIT   = 3_000_000;

   localparam lse_pkg::threshold_type THRESHOLD_MAX = 31'h7FFF_FFFF;
   localparam lse_pkg::weight_type    WEIGHT_MAX    = 16'sh7FFF;
   localparam lse_pkg::weight_type    WEIGHT_MIN    = 16'sh8000;

   typedef struct packed {
      lse_pkg::post_index_type neuron;
      logic                    fired;
      lse_pkg::membrane_type   prior;
   } eval_outcome_type;

   class lif_layer_shadow;
      lse_pkg::membrane_type  membrane [NEURONS];
      lse_pkg::weight_type    weight [INPUTS * NEURONS];
      lse_pkg::threshold_type threshold;
      lse_pkg::decay_type     decay;
      eval_outcome_type       due_evaluations [$];
      int                     absorbed;
      int                     mismatches;

      function new();
         foreach (membrane[n]) membrane[n] = '0;
         threshold  = lse_pkg::THRESHOLD_RESET;
         decay      = lse_pkg::DECAY_RESET;
         absorbed   = 0;
         mismatches = 0;
      endfunction

      function lse_pkg::membrane_type clamp(longint value);
         if (value > longint'(lse_pkg::MEMBRANE_MAX)) return lse_pkg::MEMBRANE_MAX;
         if (value < longint'(lse_pkg::MEMBRANE_MIN)) return lse_pkg::MEMBRANE_MIN;
         return lse_pkg::membrane_type'(value);
      endfunction

      function void write_reg(lse_pkg::csr_index_type idx, lse_pkg::csr_data_type data);
         unique case (idx)
            lse_pkg::CSR_FIRE_THRESHOLD: threshold = data[30:0];
            lse_pkg::CSR_DECAY_FACTOR:   decay = data[8:0];
            default: ;
         endcase
      endfunction

      function void apply_request(lse_pkg::mode_type m, lse_pkg::pre_index_type pre,
                                  lse_pkg::post_index_type post, lse_pkg::weight_type w);
         int                    base;
         lse_pkg::membrane_type v;
         logic                  fire;
         absorbed++;
         base = int'(pre) * NEURONS;
         unique case (m)
            lse_pkg::MODE_LOAD: begin
               if (pre < INPUTS && post < NEURONS) weight[base + int'(post)] = w;
            end
            lse_pkg::MODE_CLEAR: begin
               foreach (membrane[n]) membrane[n] = '0;
            end
            lse_pkg::MODE_SPIKE: begin
               if (pre < INPUTS)
                  for (int n = 0; n < NEURONS; n++)
                     membrane[n] = clamp(longint'(membrane[n]) + longint'(weight[base + n]));
            end
            default: begin
               if (post < NEURONS) begin
                  v    = membrane[post];
                  fire = longint'(v) > longint'({33'd0, threshold});
                  if (fire)
                     membrane[post] = '0;
                  else
                     membrane[post] = clamp((longint'(v) * longint'({55'd0, decay})) >>> 8);
                  due_evaluations.push_back('{post, fire, v});
               end
            end
         endcase
      endfunction

      function void check_response(lse_pkg::post_index_type neuron, logic fired,
                                   lse_pkg::membrane_type prior);
         eval_outcome_type want;
         if (due_evaluations.size() == 0) begin
            $error("unexpected response: neuron_number %0d", neuron);
            mismatches++;
            return;
         end
         want = due_evaluations.pop_front();
         if (neuron !== want.neuron) begin
            $error("neuron_number: expected %0d, actual %0d", want.neuron, neuron);
            mismatches++;
         end
         if (fired !== want.fired) begin
            $error("fired: expected %0b, actual %0b", want.fired, fired);
            mismatches++;
         end
         if (prior !== want.prior) begin
            $error("membrane_before: expected %0d, actual %0d", want.prior, prior);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lse_req_if req_ch ();
   lse_rsp_if rsp_ch ();
   lse_csr_if csr_ch ();

   lif_spiking_layer_engine #(
      .NEURONS (NEURONS),
      .INPUTS  (INPUTS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   lif_layer_shadow shadow = new();

   int issued       = 0;
   int gap_odds     = 0;
   int hold_request = 0;
   int cycle_count  = 0;

   // weight entries written so far; spikes only use complete rows
   bit written [INPUTS * NEURONS];
   int row_fill [INPUTS];
   int full_rows [$];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            shadow.check_response(rsp_ch.neuron_number, rsp_ch.fired, rsp_ch.membrane_before);
         if (req_ch.valid && req_ch.ready)
            shadow.apply_request(req_ch.mode, req_ch.pre_index, req_ch.post_index,
                                 req_ch.weight_value);
         if (csr_ch.valid && csr_ch.ready)
            shadow.write_reg(csr_ch.index, csr_ch.data);
      end
   end

   // response side: random stalls, plus long hold-offs on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left == 0 && gap_odds != 0 && $urandom_range(1, 2 * gap_odds) == 1)
            stall_left = $urandom_range(1, 16);
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic lse_pkg::weight_type pick_weight();
      unique case ($urandom_range(0, 9))
         0: return WEIGHT_MAX;
         1: return WEIGHT_MIN;
         2: return '0;
         default: return lse_pkg::weight_type'($urandom());
      endcase
   endfunction

   task automatic send_request(lse_pkg::mode_type m, lse_pkg::pre_index_type pre,
                               lse_pkg::post_index_type post, lse_pkg::weight_type w);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= m;
      req_ch.pre_index    <= pre;
      req_ch.post_index   <= post;
      req_ch.weight_value <= w;
      issued++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic issue_load(lse_pkg::pre_index_type pre, lse_pkg::post_index_type post,
                             lse_pkg::weight_type w);
      int slot;
      slot = int'(pre) * NEURONS + int'(post);
      if (!written[slot]) begin
         written[slot] = 1'b1;
         row_fill[pre]++;
         if (row_fill[pre] == NEURONS) full_rows.push_back(int'(pre));
      end
      send_request(lse_pkg::MODE_LOAD, pre, post, w);
   endtask

   task automatic spike(lse_pkg::pre_index_type pre);
      send_request(lse_pkg::MODE_SPIKE, pre, lse_pkg::post_index_type'($urandom()),
                   lse_pkg::weight_type'($urandom()));
   endtask

   task automatic evaluate(lse_pkg::post_index_type post);
      send_request(lse_pkg::MODE_EVAL, lse_pkg::pre_index_type'($urandom()), post,
                   lse_pkg::weight_type'($urandom()));
   endtask

   task automatic clear_all();
      send_request(lse_pkg::MODE_CLEAR, lse_pkg::pre_index_type'($urandom()),
                   lse_pkg::post_index_type'($urandom()), lse_pkg::weight_type'($urandom()));
   endtask

   task automatic load_row(lse_pkg::pre_index_type pre);
      int order [NEURONS];
      int j;
      int t;
      foreach (order[i]) order[i] = i;
      for (int i = NEURONS - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      foreach (order[i]) begin
         if (order[i] == 0)
            issue_load(pre, lse_pkg::post_index_type'(order[i]), WEIGHT_MAX);
         else if (order[i] == 1)
            issue_load(pre, lse_pkg::post_index_type'(order[i]), WEIGHT_MIN);
         else
            issue_load(pre, lse_pkg::post_index_type'(order[i]), pick_weight());
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock);
      while (shadow.absorbed != issued || shadow.due_evaluations.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(lse_pkg::csr_index_type idx, lse_pkg::csr_data_type data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic configure(lse_pkg::threshold_type thr, lse_pkg::decay_type dec);
      drain();
      csr_write(lse_pkg::CSR_FIRE_THRESHOLD, lse_pkg::csr_data_type'(thr));
      csr_write(lse_pkg::CSR_DECAY_FACTOR, lse_pkg::csr_data_type'(dec));
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_item(lse_pkg::post_index_type hot0, lse_pkg::post_index_type hot1);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)
         issue_load(lse_pkg::pre_index_type'($urandom()), lse_pkg::post_index_type'($urandom()),
                    pick_weight());
      else if (pick < 45)
         spike(lse_pkg::pre_index_type'(full_rows[$urandom_range(0, full_rows.size() - 1)]));
      else if (pick < 49)
         clear_all();
      else if ($urandom_range(0, 9) < 6)
         evaluate($urandom_range(0, 1) ? hot0 : hot1);
      else
         evaluate(lse_pkg::post_index_type'($urandom()));
   endtask

   initial begin
      lse_pkg::post_index_type hot0;
      lse_pkg::post_index_type hot1;

      req_ch.valid        <= 1'b0;
      req_ch.mode         <= lse_pkg::MODE_LOAD;
      req_ch.pre_index    <= '0;
      req_ch.post_index   <= '0;
      req_ch.weight_value <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= lse_pkg::CSR_FIRE_THRESHOLD;
      csr_ch.data         <= '0;
      reset               <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      gap_odds = 4;
      load_row(lse_pkg::pre_index_type'(0));
      load_row(lse_pkg::pre_index_type'(INPUTS - 1));
      load_row(lse_pkg::pre_index_type'($urandom_range(1, INPUTS - 2)));

      // reset register values, zero membranes, fire and leak paths
      evaluate(lse_pkg::post_index_type'(0));
      evaluate(lse_pkg::post_index_type'(NEURONS - 1));
      spike(lse_pkg::pre_index_type'(0));
      evaluate(lse_pkg::post_index_type'(0));
      evaluate(lse_pkg::post_index_type'(1));
      evaluate(lse_pkg::post_index_type'(1));
      spike(lse_pkg::pre_index_type'(INPUTS - 1));
      spike(lse_pkg::pre_index_type'(0));
      evaluate(lse_pkg::post_index_type'(0));
      evaluate(lse_pkg::post_index_type'(NEURONS - 1));
      evaluate(lse_pkg::post_index_type'(2));
      issue_load(lse_pkg::pre_index_type'(INPUTS - 1), lse_pkg::post_index_type'(NEURONS - 1),
                 WEIGHT_MIN);
      spike(lse_pkg::pre_index_type'(INPUTS - 1));
      evaluate(lse_pkg::post_index_type'(NEURONS - 1));
      clear_all();
      evaluate(lse_pkg::post_index_type'(0));
      evaluate(lse_pkg::post_index_type'(1));

      // leak above one drives both neurons into saturation, then spikes add on top
      configure(THRESHOLD_MAX, 9'd511);
      spike(lse_pkg::pre_index_type'(0));
      repeat (20) begin
         evaluate(lse_pkg::post_index_type'(0));
         evaluate(lse_pkg::post_index_type'(1));
      end
      spike(lse_pkg::pre_index_type'(0));
      spike(lse_pkg::pre_index_type'(INPUTS - 1));
      evaluate(lse_pkg::post_index_type'(0));
      evaluate(lse_pkg::post_index_type'(1));

      for (int p = 0; p < 8; p++) begin
         unique case (p)
            0: configure(31'd0, 9'd0);
            1: configure(THRESHOLD_MAX, 9'd256);
            2: configure(lse_pkg::THRESHOLD_RESET, lse_pkg::DECAY_RESET);
            3: configure(lse_pkg::threshold_type'($urandom()),
                         lse_pkg::decay_type'($urandom_range(0, 511)));
            4: configure(31'd0, 9'd511);
            5: configure(THRESHOLD_MAX, 9'd0);
            6: configure(lse_pkg::threshold_type'($urandom_range(0, 70000)),
                         lse_pkg::decay_type'($urandom_range(0, 256)));
            default: configure(31'd1000, 9'd300);
         endcase
         gap_odds = (p % 3 == 2) ? 0 : 2 + p;
         hot0     = lse_pkg::post_index_type'($urandom());
         hot1     = lse_pkg::post_index_type'($urandom());
         repeat (90) random_item(hot0, hot1);
      end

      // response side held off while evaluations keep coming
      drain();
      gap_odds     = 0;
      hold_request = 600;
      repeat (24) evaluate(lse_pkg::post_index_type'($urandom()));
      drain();

      configure(lse_pkg::threshold_type'($urandom_range(0, 5000)), 9'd128);
      gap_odds = 0;
      hot0     = lse_pkg::post_index_type'($urandom());
      hot1     = lse_pkg::post_index_type'($urandom());
      repeat (100) random_item(hot0, hot1);
      drain();

      if (shadow.mismatches == 0 && shadow.due_evaluations.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/lse_pkg.sv
design/lse_channels.sv
design/lse_weight_mem.sv
design/lse_leak_unit.sv
design/lif_spiking_layer_engine.sv
tb/sv/tb.sv
